// ----- design/assert_macros.svh -----
// assertion macros for the rtl files
// no dependencies; simulation gets the checks, synthesis gets empty bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, gated by an active-low reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, gated by an active-low reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- design/lrupr_pkg.sv -----
// shared constants and types for the lru page replacement block
// no dependencies; used by lrupr_cell and lru_page_replacement
package lrupr_pkg;

    // default sizing
    localparam int DEF_MAX_FRAMES = 16;
    localparam int DEF_PAGE_BITS  = 16;

    // fixed field widths
    localparam int TIME_W      = 32;
    localparam int FAULT_W     = 32;
    localparam int CFG_W       = 5;
    localparam int FRAME_IDX_W = 4;

    // register port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int REG_IDX_W  = 1;
    localparam logic [REG_IDX_W-1:0] REG_FRAMES_IN_USE = 1'b0;
    localparam logic [CFG_W-1:0]     CFG_FRAMES_RESET  = 5'd16;

    // control flags of the search word passed from cell to cell
    typedef struct packed {
        logic valid;     // a search word is present
        logic hit;       // a matching resident frame was seen
        logic empty;     // an empty frame was seen
        logic have_old;  // an oldest candidate was recorded
    } t_scan_flags;

endpackage

// ----- design/lrupr_cell.sv -----
// one frame of the replacement chain: holds page, valid mark and last-use time
// depends on lrupr_pkg; instantiated in a row by lru_page_replacement
module lrupr_cell #(
    parameter int MAX_FRAMES = lrupr_pkg::DEF_MAX_FRAMES,
    parameter int PAGE_BITS  = lrupr_pkg::DEF_PAGE_BITS,
    parameter int CELL_IDX   = 0,
    localparam int IDX_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_active,
    // search word from the previous cell
    input  lrupr_pkg::t_scan_flags        i_flags,
    input  logic [PAGE_BITS-1:0]          i_page,
    input  logic [IDX_W-1:0]              i_hit_idx,
    input  logic [IDX_W-1:0]              i_empty_idx,
    input  logic [IDX_W-1:0]              i_old_idx,
    input  logic [lrupr_pkg::TIME_W-1:0]  i_old_time,
    input  logic [PAGE_BITS-1:0]          i_old_page,
    // search word to the next cell
    output lrupr_pkg::t_scan_flags        o_flags,
    output logic [PAGE_BITS-1:0]          o_page,
    output logic [IDX_W-1:0]              o_hit_idx,
    output logic [IDX_W-1:0]              o_empty_idx,
    output logic [IDX_W-1:0]              o_old_idx,
    output logic [lrupr_pkg::TIME_W-1:0]  o_old_time,
    output logic [PAGE_BITS-1:0]          o_old_page,
    // frame write broadcast
    input  logic                          i_upd_en,
    input  logic [IDX_W-1:0]              i_upd_idx,
    input  logic [PAGE_BITS-1:0]          i_upd_page,
    input  logic [lrupr_pkg::TIME_W-1:0]  i_upd_time
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    // frame contents
    logic                          r_valid;
    logic [PAGE_BITS-1:0]          r_page;
    logic [lrupr_pkg::TIME_W-1:0]  r_time;

    // outgoing search word
    lrupr_pkg::t_scan_flags        r_flags, n_flags;
    logic [PAGE_BITS-1:0]          r_spage;
    logic [IDX_W-1:0]              r_hit_idx, n_hit_idx;
    logic [IDX_W-1:0]              r_empty_idx, n_empty_idx;
    logic [IDX_W-1:0]              r_old_idx, n_old_idx;
    logic [lrupr_pkg::TIME_W-1:0]  r_old_time, n_old_time;
    logic [PAGE_BITS-1:0]          r_old_page, n_old_page;

    // fold this frame into the search word
    always_comb begin
        n_flags     = i_flags;
        n_hit_idx   = i_hit_idx;
        n_empty_idx = i_empty_idx;
        n_old_idx   = i_old_idx;
        n_old_time  = i_old_time;
        n_old_page  = i_old_page;
        if (i_active) begin
            if (!i_flags.hit && r_valid && (r_page == i_page)) begin
                n_flags.hit = 1'b1;
                n_hit_idx   = MY_IDX;
            end
            if (!i_flags.empty && !r_valid) begin
                n_flags.empty = 1'b1;
                n_empty_idx   = MY_IDX;
            end
            // strict compare keeps the lower index on a tie
            if (!i_flags.have_old || (r_time < i_old_time)) begin
                n_flags.have_old = 1'b1;
                n_old_idx        = MY_IDX;
                n_old_time       = r_time;
                n_old_page       = r_page;
            end
        end
    end

    // search word advances one cell per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else begin
            r_flags <= n_flags;
        end
        r_spage     <= i_page;
        r_hit_idx   <= n_hit_idx;
        r_empty_idx <= n_empty_idx;
        r_old_idx   <= n_old_idx;
        r_old_time  <= n_old_time;
        r_old_page  <= n_old_page;
    end

    // frame write on a hit refresh, a fill or a replacement
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_upd_en && (i_upd_idx == MY_IDX)) begin
            r_valid <= 1'b1;
        end
        if (i_upd_en && (i_upd_idx == MY_IDX)) begin
            r_page <= i_upd_page;
            r_time <= i_upd_time;
        end
    end

    assign o_flags     = r_flags;
    assign o_page      = r_spage;
    assign o_hit_idx   = r_hit_idx;
    assign o_empty_idx = r_empty_idx;
    assign o_old_idx   = r_old_idx;
    assign o_old_time  = r_old_time;
    assign o_old_page  = r_old_page;

endmodule

// ----- design/lru_page_replacement.sv -----
// top level of the lru page replacement block: register port, scan control, result register
// depends on lrupr_pkg, lrupr_cell and assert_macros.svh
//
// One page reference is handled at a time. An accepted word starts a search that walks the
// row of MAX_FRAMES frame cells, one cell per clock, collecting the first matching frame, the
// first empty frame and the oldest frame. The outcome is then held in the tail registers;
// once the output register is free, the chosen frame is written and the result is loaded.
// A new page is taken only after that result is loaded, since o_ready is high only in idle.
// The register frames_in_use (byte address 0) selects how many frames, from frame 0, take
// part; 0 acts as 1 and values above MAX_FRAMES act as MAX_FRAMES. Write it only while idle.
// No clearing pass is needed after reset.
`include "assert_macros.svh"

module lru_page_replacement #(
    parameter int MAX_FRAMES = lrupr_pkg::DEF_MAX_FRAMES,
    parameter int PAGE_BITS  = lrupr_pkg::DEF_PAGE_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // reference words
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [PAGE_BITS-1:0]                 i_page,
    // result words
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic                                 o_hit,
    output logic [lrupr_pkg::FRAME_IDX_W-1:0]    o_frame_index,
    output logic                                 o_evicted_valid,
    output logic [PAGE_BITS-1:0]                 o_evicted_page,
    output logic [lrupr_pkg::FAULT_W-1:0]        o_fault_total,
    // register port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [lrupr_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [lrupr_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [lrupr_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                 pready
);

    localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W = $clog2(MAX_FRAMES + 1);
    localparam int CMP_W = (CNT_W > lrupr_pkg::CFG_W) ? CNT_W : lrupr_pkg::CFG_W;
    localparam int TW    = lrupr_pkg::TIME_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    // register port
    logic [lrupr_pkg::CFG_W-1:0]     r_frames_in_use;
    logic [lrupr_pkg::REG_IDX_W-1:0] w_reg_idx;
    logic                            w_cfg_wr;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_in_use <= lrupr_pkg::CFG_FRAMES_RESET;
        end else if (w_cfg_wr && (w_reg_idx == lrupr_pkg::REG_FRAMES_IN_USE)) begin
            r_frames_in_use <= pwdata[lrupr_pkg::CFG_W-1:0];
        end
    end

    // register read
    always_comb begin
        prdata = '0;
        case (w_reg_idx)
            lrupr_pkg::REG_FRAMES_IN_USE:
                prdata = lrupr_pkg::APB_DATA_W'(r_frames_in_use);
            default:
                prdata = '0;
        endcase
    end

    // active frame count, clamped to one..MAX_FRAMES, and per-cell enables
    logic [CMP_W-1:0]      w_count;
    logic [MAX_FRAMES-1:0] w_active;

    always_comb begin
        w_count = CMP_W'(r_frames_in_use);
        if (w_count == '0) begin
            w_count = CMP_W'(1);
        end else if (w_count > CMP_W'(MAX_FRAMES)) begin
            w_count = CMP_W'(MAX_FRAMES);
        end
        for (int k = 0; k < MAX_FRAMES; k++) begin
            w_active[k] = (CMP_W'(k) < w_count);
        end
    end

    // control state
    t_state                  r_state, n_state;
    logic                    r_start;
    logic [PAGE_BITS-1:0]    r_req_page;
    logic [TW-1:0]           r_ref_clock;
    logic [lrupr_pkg::FAULT_W-1:0] r_fault_count;
    logic                    r_out_valid;
    logic                    w_accept;
    logic                    w_finish;
    logic                    w_tail_valid;

    // search words between cells
    lrupr_pkg::t_scan_flags  w_flags     [MAX_FRAMES+1];
    logic [PAGE_BITS-1:0]    w_page      [MAX_FRAMES+1];
    logic [IDX_W-1:0]        w_hit_idx   [MAX_FRAMES+1];
    logic [IDX_W-1:0]        w_empty_idx [MAX_FRAMES+1];
    logic [IDX_W-1:0]        w_old_idx   [MAX_FRAMES+1];
    logic [TW-1:0]           w_old_time  [MAX_FRAMES+1];
    logic [PAGE_BITS-1:0]    w_old_page  [MAX_FRAMES+1];

    // frame write broadcast
    logic                    w_upd_en;
    logic [IDX_W-1:0]        w_upd_idx;

    // captured outcome of the walk
    lrupr_pkg::t_scan_flags  r_tail_flags;
    logic [IDX_W-1:0]        r_tail_hit_idx;
    logic [IDX_W-1:0]        r_tail_empty_idx;
    logic [IDX_W-1:0]        r_tail_old_idx;
    logic [PAGE_BITS-1:0]    r_tail_old_page;

    assign o_ready      = (r_state == ST_IDLE);
    assign w_accept     = i_valid && o_ready;
    assign w_tail_valid = w_flags[MAX_FRAMES].valid;
    assign w_finish     = (r_state == ST_DONE) && (!r_out_valid || i_ready);

    // search word entering cell 0
    always_comb begin
        w_flags[0]       = '0;
        w_flags[0].valid = r_start;
        w_page[0]        = r_req_page;
        w_hit_idx[0]     = '0;
        w_empty_idx[0]   = '0;
        w_old_idx[0]     = '0;
        w_old_time[0]    = '0;
        w_old_page[0]    = '0;
    end

    // row of frame cells
    for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
        lrupr_cell #(
            .MAX_FRAMES (MAX_FRAMES),
            .PAGE_BITS  (PAGE_BITS),
            .CELL_IDX   (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_active    (w_active[g]),
            .i_flags     (w_flags[g]),
            .i_page      (w_page[g]),
            .i_hit_idx   (w_hit_idx[g]),
            .i_empty_idx (w_empty_idx[g]),
            .i_old_idx   (w_old_idx[g]),
            .i_old_time  (w_old_time[g]),
            .i_old_page  (w_old_page[g]),
            .o_flags     (w_flags[g+1]),
            .o_page      (w_page[g+1]),
            .o_hit_idx   (w_hit_idx[g+1]),
            .o_empty_idx (w_empty_idx[g+1]),
            .o_old_idx   (w_old_idx[g+1]),
            .o_old_time  (w_old_time[g+1]),
            .o_old_page  (w_old_page[g+1]),
            .i_upd_en    (w_upd_en),
            .i_upd_idx   (w_upd_idx),
            .i_upd_page  (r_req_page),
            .i_upd_time  (r_ref_clock)
        );
    end

    // victim choice: matching frame, else first empty, else oldest
    logic w_evict;

    always_comb begin
        w_evict = !r_tail_flags.hit && !r_tail_flags.empty;
        if (r_tail_flags.hit) begin
            w_upd_idx = r_tail_hit_idx;
        end else if (r_tail_flags.empty) begin
            w_upd_idx = r_tail_empty_idx;
        end else begin
            w_upd_idx = r_tail_old_idx;
        end
        w_upd_en = w_finish;
    end

    // sequencing
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_accept)     n_state = ST_SCAN;
            ST_SCAN: if (w_tail_valid) n_state = ST_DONE;
            ST_DONE: if (w_finish)     n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_start       <= 1'b0;
            r_ref_clock   <= '0;
            r_fault_count <= '0;
        end else begin
            r_state <= n_state;
            r_start <= w_accept;
            if (w_finish) begin
                r_ref_clock <= r_ref_clock + TW'(1);
                if (!r_tail_flags.hit) begin
                    r_fault_count <= r_fault_count + lrupr_pkg::FAULT_W'(1);
                end
            end
        end
    end

    // request page and walk outcome
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req_page <= i_page;
        end
        if (w_tail_valid) begin
            r_tail_flags     <= w_flags[MAX_FRAMES];
            r_tail_hit_idx   <= w_hit_idx[MAX_FRAMES];
            r_tail_empty_idx <= w_empty_idx[MAX_FRAMES];
            r_tail_old_idx   <= w_old_idx[MAX_FRAMES];
            r_tail_old_page  <= w_old_page[MAX_FRAMES];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_finish) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_finish) begin
            o_hit           <= r_tail_flags.hit;
            o_frame_index   <= lrupr_pkg::FRAME_IDX_W'(w_upd_idx);
            o_evicted_valid <= w_evict;
            o_evicted_page  <= w_evict ? r_tail_old_page : '0;
            o_fault_total   <= r_tail_flags.hit ? r_fault_count
                                                : r_fault_count + lrupr_pkg::FAULT_W'(1);
        end
    end

    assign o_valid = r_out_valid;

    // checks
    `ASSERT_NEXT(a_accept_starts_scan, i_clk, i_rst_n, w_accept, r_state == ST_SCAN && r_start)
    `ASSERT_IMPLY(a_tail_only_in_scan, i_clk, i_rst_n, w_tail_valid, r_state == ST_SCAN)
    `ASSERT_NEXT(a_finish_loads_result, i_clk, i_rst_n, w_finish, r_out_valid && o_ready)
    `ASSERT_NEXT(a_fault_steady, i_clk, i_rst_n, !w_finish, $stable(r_fault_count))

endmodule

// ----- tb/lru_page_replacement_test.sv -----
// self-checking testbench for lru_page_replacement: directed table, then random page streams
// depends on lrupr_pkg and the lru_page_replacement rtl; predicts result words itself, but for typed table rows
module lru_page_replacement_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAMES      = lrupr_pkg::DEF_MAX_FRAMES;
    localparam int PAGE_W      = lrupr_pkg::DEF_PAGE_BITS;
    localparam int TIME_W      = lrupr_pkg::TIME_W;
    localparam int FAULT_W     = lrupr_pkg::FAULT_W;
    localparam int CFG_W       = lrupr_pkg::CFG_W;
    localparam int FRAME_IDX_W = lrupr_pkg::FRAME_IDX_W;
    localparam int APB_ADDR_W  = lrupr_pkg::APB_ADDR_W;
    localparam int APB_DATA_W  = lrupr_pkg::APB_DATA_W;
    localparam int DRAIN       = FRAMES + 3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 9;
    localparam int PHASE_ITEMS = 56;
    localparam int POOL_SIZE   = 24;
    localparam int PLAN_ROWS   = 28;
    localparam logic [APB_ADDR_W-1:0] FRAMES_ADDR =
        APB_ADDR_W'(4 * lrupr_pkg::REG_FRAMES_IN_USE);

    typedef struct packed {
        logic                   hit;
        logic [FRAME_IDX_W-1:0] frame_index;
        logic                   evicted_valid;
        logic [PAGE_W-1:0]      evicted_page;
        logic [FAULT_W-1:0]     fault_total;
    } t_lru_result;

    // one row of the directed table: a register write or a page word
    typedef struct {
        bit                is_cfg;
        logic [CFG_W-1:0]  cfg;
        logic [PAGE_W-1:0] page;
        bit                typed;
        t_lru_result       want;
    } t_plan_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_ready;
    logic [PAGE_W-1:0]       i_page = '0;
    logic                    o_valid;
    logic                    i_ready = 1'b0;
    logic                    o_hit;
    logic [FRAME_IDX_W-1:0]  o_frame_index;
    logic                    o_evicted_valid;
    logic [PAGE_W-1:0]       o_evicted_page;
    logic [FAULT_W-1:0]      o_fault_total;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr = '0;
    logic [APB_DATA_W-1:0]   pwdata = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;

    lru_page_replacement #(
        .MAX_FRAMES (FRAMES),
        .PAGE_BITS  (PAGE_W)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_page          (i_page),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_hit           (o_hit),
        .o_frame_index   (o_frame_index),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .o_fault_total   (o_fault_total),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // shadow copy of the frame table
    logic [PAGE_W-1:0]  shadow_page  [FRAMES];
    logic               shadow_valid [FRAMES];
    logic [TIME_W-1:0]  shadow_stamp [FRAMES];
    logic [TIME_W-1:0]  shadow_now;
    logic [FAULT_W-1:0] shadow_faults;
    logic [CFG_W-1:0]   shadow_frames;

    t_lru_result pending_results [$];
    int          mismatch_count = 0;
    int          words_seen = 0;
    int          cycle_count = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    t_lru_result seen_word;
    t_lru_result oldest_want;

    // directed table: extremes, hits, shrink to one frame, duplicates, lru order, regrow
    t_plan_row plan [PLAN_ROWS] = '{
        '{1'b0, 5'd0,  16'h0000, 1'b1, '{1'b0, 4'd0, 1'b0, 16'h0000, 32'd1}},
        '{1'b0, 5'd0,  16'hFFFF, 1'b1, '{1'b0, 4'd1, 1'b0, 16'h0000, 32'd2}},
        '{1'b0, 5'd0,  16'h0000, 1'b1, '{1'b1, 4'd0, 1'b0, 16'h0000, 32'd2}},
        '{1'b0, 5'd0,  16'hFFFF, 1'b1, '{1'b1, 4'd1, 1'b0, 16'h0000, 32'd2}},
        '{1'b0, 5'd0,  16'hAAAA, 1'b1, '{1'b0, 4'd2, 1'b0, 16'h0000, 32'd3}},
        '{1'b0, 5'd0,  16'h5555, 1'b1, '{1'b0, 4'd3, 1'b0, 16'h0000, 32'd4}},
        '{1'b1, 5'd0,  16'h0000, 1'b0, '0},
        '{1'b0, 5'd0,  16'h1234, 1'b1, '{1'b0, 4'd0, 1'b1, 16'h0000, 32'd5}},
        '{1'b0, 5'd0,  16'h1234, 1'b1, '{1'b1, 4'd0, 1'b0, 16'h0000, 32'd5}},
        '{1'b0, 5'd0,  16'hFFFF, 1'b1, '{1'b0, 4'd0, 1'b1, 16'h1234, 32'd6}},
        '{1'b1, 5'd31, 16'h0000, 1'b0, '0},
        '{1'b0, 5'd0,  16'hFFFF, 1'b1, '{1'b1, 4'd0, 1'b0, 16'h0000, 32'd6}},
        '{1'b1, 5'd2,  16'h0000, 1'b0, '0},
        '{1'b0, 5'd0,  16'h0001, 1'b1, '{1'b0, 4'd1, 1'b1, 16'hFFFF, 32'd7}},
        '{1'b0, 5'd0,  16'hFFFF, 1'b0, '0},
        '{1'b0, 5'd0,  16'h0002, 1'b0, '0},
        '{1'b0, 5'd0,  16'h0003, 1'b0, '0},
        '{1'b1, 5'd16, 16'h0000, 1'b0, '0},
        '{1'b0, 5'd0,  16'hAAAA, 1'b0, '0},
        '{1'b0, 5'd0,  16'h5555, 1'b0, '0},
        '{1'b0, 5'd0,  16'h8000, 1'b0, '0},
        '{1'b0, 5'd0,  16'h7FFF, 1'b0, '0},
        '{1'b0, 5'd0,  16'h0100, 1'b0, '0},
        '{1'b0, 5'd0,  16'h00FF, 1'b0, '0},
        '{1'b0, 5'd0,  16'hF00F, 1'b0, '0},
        '{1'b0, 5'd0,  16'h0FF0, 1'b0, '0},
        '{1'b0, 5'd0,  16'h0003, 1'b0, '0},
        '{1'b0, 5'd0,  16'h1357, 1'b0, '0}
    };

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // lookup and replacement on the shadow table, one page reference
    function automatic t_lru_result lru_lookup(input logic [PAGE_W-1:0] page);
        t_lru_result       res;
        int                active;
        int                slot;
        int                i;
        bit                found;
        bit                have_empty;
        logic [TIME_W-1:0] oldest;
        res = '0;
        active = int'(shadow_frames);
        if (active < 1) active = 1;
        if (active > FRAMES) active = FRAMES;
        slot = 0;
        found = 1'b0;
        for (i = 0; i < active && !found; i++) begin
            if (shadow_valid[i] && shadow_page[i] == page) begin
                slot = i;
                found = 1'b1;
            end
        end
        if (found) begin
            shadow_stamp[slot] = shadow_now;
            res.hit = 1'b1;
        end else begin
            shadow_faults = shadow_faults + 1'b1;
            have_empty = 1'b0;
            for (i = 0; i < active && !have_empty; i++) begin
                if (!shadow_valid[i]) begin
                    slot = i;
                    have_empty = 1'b1;
                end
            end
            // full: oldest stamp, lowest index on a tie
            if (!have_empty) begin
                slot = 0;
                oldest = shadow_stamp[0];
                for (i = 1; i < active; i++) begin
                    if (shadow_stamp[i] < oldest) begin
                        oldest = shadow_stamp[i];
                        slot = i;
                    end
                end
                res.evicted_valid = 1'b1;
                res.evicted_page = shadow_page[slot];
            end
            shadow_page[slot] = page;
            shadow_valid[slot] = 1'b1;
            shadow_stamp[slot] = shadow_now;
        end
        shadow_now = shadow_now + 1'b1;
        res.frame_index = FRAME_IDX_W'(slot);
        res.fault_total = shadow_faults;
        return res;
    endfunction

    // offer one page word, with random idle cycles ahead of it
    task automatic send_page(input logic [PAGE_W-1:0] page, input bit gaps, input bit typed,
                             input t_lru_result typed_want);
        t_lru_result predicted;
        while (gaps && $urandom_range(0, 99) < 18) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_page <= page;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        predicted = lru_lookup(page);
        pending_results.push_back(typed ? typed_want : predicted);
        @(negedge i_clk);
    endtask

    // drain, then write frames_in_use and read it back
    task automatic set_frames(input int value);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= FRAMES_ADDR;
        pwdata <= APB_DATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[CFG_W-1:0] !== CFG_W'(value)) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("frames_in_use readback: want %0d got %0d", value, prdata[CFG_W-1:0]);
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        shadow_frames = CFG_W'(value);
    endtask

    // result side: random stalls, one long hold-off, one stretch always ready
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (!hold_done && words_seen >= 200) begin
            i_ready <= 1'b0;
            hold_left = 400;
            hold_done = 1'b1;
        end else if (words_seen >= 300 && words_seen < 380) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= 18);
        end
    end

    // compare each result word with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            words_seen++;
            seen_word = '{o_hit, o_frame_index, o_evicted_valid, o_evicted_page, o_fault_total};
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result word %0d: %p", words_seen, seen_word);
            end else begin
                oldest_want = pending_results.pop_front();
                if (seen_word.hit !== oldest_want.hit
                        || seen_word.frame_index !== oldest_want.frame_index
                        || seen_word.evicted_valid !== oldest_want.evicted_valid
                        || seen_word.evicted_page !== oldest_want.evicted_page
                        || seen_word.fault_total !== oldest_want.fault_total) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("word %0d: want hit=%0b frame=%0d ev=%0b/%h faults=%0d",
                                 words_seen, oldest_want.hit, oldest_want.frame_index,
                                 oldest_want.evicted_valid, oldest_want.evicted_page,
                                 oldest_want.fault_total);
                        $display("word %0d: got  hit=%0b frame=%0d ev=%0b/%h faults=%0d",
                                 words_seen, seen_word.hit, seen_word.frame_index,
                                 seen_word.evicted_valid, seen_word.evicted_page,
                                 seen_word.fault_total);
                    end
                end
            end
        end
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // stimulus
    initial begin
        int                r;
        int                p;
        int                k;
        int                sel;
        int                active;
        int                pool_used;
        int                item_no;
        int                phase_frames [PHASES];
        logic [PAGE_W-1:0] pool [POOL_SIZE];
        logic [PAGE_W-1:0] page;
        logic [PAGE_W-1:0] last_page;

        for (r = 0; r < FRAMES; r++) begin
            shadow_page[r] = '0;
            shadow_valid[r] = 1'b0;
            shadow_stamp[r] = '0;
        end
        shadow_now = '0;
        shadow_faults = '0;
        shadow_frames = lrupr_pkg::CFG_FRAMES_RESET;
        phase_frames = '{16, 1, 3, 0, 8, 31, 17, 5, 0};
        phase_frames[PHASES-1] = $urandom_range(0, 31);
        last_page = '0;
        item_no = 0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table
        for (r = 0; r < PLAN_ROWS; r++) begin
            if (plan[r].is_cfg)
                set_frames(plan[r].cfg);
            else
                send_page(plan[r].page, 1'b1, plan[r].typed, plan[r].want);
        end

        // random phases: mostly a working set near the frame count, some noise
        for (p = 0; p < PHASES; p++) begin
            set_frames(phase_frames[p]);
            active = phase_frames[p];
            if (active < 1) active = 1;
            if (active > FRAMES) active = FRAMES;
            pool_used = active + $urandom_range(0, 4);
            if (pool_used > POOL_SIZE) pool_used = POOL_SIZE;
            for (k = 0; k < POOL_SIZE; k++) pool[k] = PAGE_W'($urandom);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                sel = $urandom_range(0, 99);
                if (sel < 70)
                    page = pool[$urandom_range(0, pool_used - 1)];
                else if (sel < 85)
                    page = PAGE_W'($urandom);
                else if (sel < 92)
                    page = $urandom_range(0, 1) ? '1 : '0;
                else
                    page = last_page;
                last_page = page;
                send_page(page, !(item_no >= 100 && item_no < 180), 1'b0, '0);
                item_no++;
            end
        end

        // let the last results come back
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (2 * DRAIN) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
